// ===== hdl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// types and constants shared by the sorted run merger
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int NUM_RUNS = 8;
  localparam int NUM_KEYS = 2;
  localparam int RUN_W = $clog2(NUM_RUNS);

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_EXHAUST = 2'd1,
    KIND_POP = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_LIMIT = 2'd0,
    REG_KEYCNT = 2'd1,
    REG_ASC = 2'd2,
    REG_NULLF = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  run_id;
    logic [31:0] row_index;
    logic signed [63:0] key_first;
    logic        key_first_null;
    logic signed [63:0] key_second;
    logic        key_second_null;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_run;
    logic [31:0] out_row;
    logic        out_done;
  } out_item_t;

  typedef struct packed {
    logic [63:0] k0;
    logic [63:0] k1;
    logic [1:0]  nulls;
    logic [31:0] row;
  } head_t;

  typedef struct packed {
    logic [1:0] key_count;
    logic [1:0] asc;
    logic [1:0] null_lead;
  } order_cfg_t;

endpackage

// ===== hdl/k_way_sorted_run_merger.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_run_merger
// merges sorted runs: holds one head per run in a memory, pops the smallest
// ----------------------------------------------------------------------------
// load, exhausted and clear items act at the accepting edge and never raise busy
// a pop with heads present, limit not reached, reads one run per cycle and holds
// busy through scan, last and emit, taking no new item; the result follows emit
// a pop that answers done strobes out_valid the next cycle without raising busy
// results stay one cycle only on out_valid; the receiver cannot stall
// sync active-low reset clears present bits, count, registers and fsm, not memory
module k_way_sorted_run_merger (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kwm_pkg::in_item_t   in_item,
  output logic                out_valid,
  output kwm_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  localparam int RW = kwm_pkg::RUN_W;

  // configuration registers
  logic [32:0] limit_r;
  logic [1:0]  kcnt_r, asc_r, nullf_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:3];

  // limit is 33 bits signed; bit 32 set means no limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
      kcnt_r  <= 2'd1;
      asc_r   <= 2'd3;
      nullf_r <= 2'd0;
    end else if (cfg_wr) begin
      unique case (kwm_pkg::reg_idx_t'(cfg_idx))
        kwm_pkg::REG_LIMIT:  limit_r <= pwdata[32:0];
        kwm_pkg::REG_KEYCNT: kcnt_r  <= pwdata[1:0];
        kwm_pkg::REG_ASC:    asc_r   <= pwdata[1:0];
        kwm_pkg::REG_NULLF:  nullf_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (kwm_pkg::reg_idx_t'(cfg_idx))
      kwm_pkg::REG_LIMIT:  prdata = {{31{limit_r[32]}}, limit_r};
      kwm_pkg::REG_KEYCNT: prdata = {62'd0, kcnt_r};
      kwm_pkg::REG_ASC:    prdata = {62'd0, asc_r};
      kwm_pkg::REG_NULLF:  prdata = {62'd0, nullf_r};
      default:             prdata = '0;
    endcase
  end

  // head memory, one entry per run, one read port with registered data
  kwm_pkg::head_t head_mem [kwm_pkg::NUM_RUNS];
  kwm_pkg::head_t rd_q;
  logic [RW-1:0]  rd_addr;
  logic           mem_we;
  logic [RW-1:0]  wr_addr;
  kwm_pkg::head_t wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) head_mem[wr_addr] <= wr_data;
    rd_q <= head_mem[rd_addr];
  end

  // control state
  kwm_pkg::state_t state_r, state_nxt;
  logic [kwm_pkg::NUM_RUNS-1:0] present_r, present_nxt;
  logic [31:0]    count_r, count_nxt;
  logic [RW:0]    scan_r, scan_nxt;        // read address being issued
  logic [RW-1:0]  cand_r, cand_nxt;        // run whose data is in rd_q
  logic           found_r, found_nxt;
  logic [RW-1:0]  best_r, best_nxt;
  kwm_pkg::head_t best_q, best_d;
  logic           best_we;
  logic           cand_live;
  logic           cand_less;
  logic           take;
  logic           limited;
  kwm_pkg::order_cfg_t ocfg;
  kwm_pkg::in_item_t in_q;
  logic           out_valid_r, out_valid_nxt;
  kwm_pkg::out_item_t out_r, out_nxt;

  assign ocfg = '{key_count: kcnt_r, asc: asc_r, null_lead: nullf_r};

  kwm_cmp u_cmp (
    .a(rd_q),
    .b(best_q),
    .cfg(ocfg),
    .less(cand_less)
  );

  assign in_q = in_item;
  assign busy = (state_r != kwm_pkg::ST_IDLE);
  assign limited = !limit_r[32] && ({1'b0, count_r} >= limit_r);
  assign cand_live = present_r[cand_r];
  assign take = cand_live && (!found_r || cand_less);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kwm_pkg::ST_IDLE;
      present_r   <= '0;
      count_r     <= '0;
      scan_r      <= '0;
      cand_r      <= '0;
      found_r     <= 1'b0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      cand_r      <= cand_nxt;
      found_r     <= found_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (best_we) best_q <= best_d;
  end

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    cand_nxt      = cand_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    wr_addr       = in_q.run_id[RW-1:0];
    wr_data       = '{k0: in_q.key_first, k1: in_q.key_second,
                      nulls: {in_q.key_second_null, in_q.key_first_null},
                      row: in_q.row_index};
    rd_addr       = scan_r[RW-1:0];
    best_we       = 1'b0;
    best_d        = rd_q;
    unique case (state_r)
      kwm_pkg::ST_IDLE: begin
        if (start) begin
          case (kwm_pkg::kind_t'(in_q.kind))
            kwm_pkg::KIND_LOAD: begin
              if (32'(in_q.run_id) < 32'(kwm_pkg::NUM_RUNS)) begin
                mem_we = 1'b1;
                present_nxt[in_q.run_id[RW-1:0]] = 1'b1;
              end
            end
            kwm_pkg::KIND_EXHAUST: begin
              if (32'(in_q.run_id) < 32'(kwm_pkg::NUM_RUNS))
                present_nxt[in_q.run_id[RW-1:0]] = 1'b0;
            end
            kwm_pkg::KIND_CLEAR: begin
              present_nxt = '0;
              count_nxt   = '0;
            end
            default: begin
              if (limited || present_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{out_run: 3'd0, out_row: 32'd0, out_done: 1'b1};
              end else begin
                rd_addr   = '0;
                scan_nxt  = (RW+1)'(1);
                cand_nxt  = '0;
                found_nxt = 1'b0;
                state_nxt = kwm_pkg::ST_SCAN;
              end
            end
          endcase
        end
      end
      kwm_pkg::ST_SCAN, kwm_pkg::ST_LAST: begin
        // rd_q holds run cand_r; compare against best so far
        if (take) begin
          best_we   = 1'b1;
          best_nxt  = cand_r;
          found_nxt = 1'b1;
        end
        cand_nxt = scan_r[RW-1:0];
        scan_nxt = scan_r + (RW+1)'(1);
        if (state_r == kwm_pkg::ST_LAST) state_nxt = kwm_pkg::ST_EMIT;
        else if (scan_r == (RW+1)'(kwm_pkg::NUM_RUNS - 1)) state_nxt = kwm_pkg::ST_LAST;
      end
      kwm_pkg::ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_nxt = '{out_run: 3'(best_r), out_row: best_q.row, out_done: 1'b0};
        present_nxt[best_r] = 1'b0;
        if (count_r != '1) count_nxt = count_r + 32'd1;
        state_nxt = kwm_pkg::ST_IDLE;
      end
      default: state_nxt = kwm_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  // a pop that finds heads always marks one as best before emitting
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kwm_pkg::ST_EMIT |-> found_r && present_r[best_r])
    else $error("emit without a present best head");
  // a non-done result clears the popped run's present bit
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kwm_pkg::ST_EMIT |=> !present_r[$past(best_r)])
    else $error("popped head still present");
  // results only appear after the block was busy or just started
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy) || $past(state_r == kwm_pkg::ST_EMIT))
    else $error("stray result strobe");
`endif

endmodule

// ===== hdl/kwm_cmp.sv =====
// ----------------------------------------------------------------------------
// kwm_cmp
// orders two heads by the configured keys; less is high if a goes first
// ----------------------------------------------------------------------------
module kwm_cmp (
  input  kwm_pkg::head_t      a,
  input  kwm_pkg::head_t      b,
  input  kwm_pkg::order_cfg_t cfg,
  output logic                less
);
  logic [1:0] n_use;
  logic [1:0] lt, gt;
  logic [63:0] ka, kb;
  logic na, nb, slt, sgt;

  always_comb begin
    n_use = (cfg.key_count > 2'(kwm_pkg::NUM_KEYS)) ? 2'(kwm_pkg::NUM_KEYS) : cfg.key_count;
    for (int i = 0; i < 2; i++) begin
      ka = (i == 0) ? a.k0 : a.k1;
      kb = (i == 0) ? b.k0 : b.k1;
      na = a.nulls[i];
      nb = b.nulls[i];
      slt = $signed(ka) < $signed(kb);
      sgt = $signed(ka) > $signed(kb);
      if (na || nb) begin
        lt[i] = (na != nb) && (na == cfg.null_lead[i]);
        gt[i] = (na != nb) && (na != cfg.null_lead[i]);
      end else begin
        lt[i] = cfg.asc[i] ? slt : sgt;
        gt[i] = cfg.asc[i] ? sgt : slt;
      end
    end
    less = 1'b0;
    if (n_use >= 2'd1) begin
      if (lt[0]) less = 1'b1;
      else if (!gt[0] && n_use >= 2'd2) less = lt[1];
    end
  end
endmodule

// ===== test/tb_k_way_sorted_run_merger.sv =====
// ----------------------------------------------------------------------------
// tb_k_way_sorted_run_merger
// self-checking bench for the sorted run merger: a queue-fed driver sends
// load, exhausted, pop and clear items with random gaps, a clocked monitor
// tracks the head table and predicts each pop, and results are compared
// field by field against the oldest prediction across several orderings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_k_way_sorted_run_merger;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  kwm_pkg::in_item_t in_item;
  logic out_valid;
  kwm_pkg::out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  k_way_sorted_run_merger dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // pending items for the driver, pop results still owed by the block
  kwm_pkg::in_item_t pending_items[$];
  kwm_pkg::out_item_t owed_pops[$];

  // shadow of the ordering registers
  logic limit_off;
  logic [31:0] limit_val;
  logic [1:0] keys_used;
  logic [1:0] asc_bits;
  logic [1:0] null_lead_bits;

  // shadow of the head table
  logic signed [63:0] sh_key0[kwm_pkg::NUM_RUNS];
  logic signed [63:0] sh_key1[kwm_pkg::NUM_RUNS];
  logic [1:0] sh_nulls[kwm_pkg::NUM_RUNS];
  logic [31:0] sh_row[kwm_pkg::NUM_RUNS];
  logic sh_present[kwm_pkg::NUM_RUNS];
  logic [31:0] rows_emitted;

  logic took_item;
  int mismatches;
  int pops_checked;
  int done_seen;
  int items_sent;
  int gap_left;
  logic calm;

  // negative when run a orders ahead of run b, positive when behind
  function automatic int order_runs(int a, int b);
    int n;
    int c;
    logic na;
    logic nb;
    n = (keys_used > 2) ? 2 : keys_used;
    for (int i = 0; i < n; i++) begin
      na = sh_nulls[a][i];
      nb = sh_nulls[b][i];
      if (na || nb) begin
        if (na == nb) continue;
        c = null_lead_bits[i] ? -1 : 1;
        return na ? c : -c;
      end
      if (i == 0) c = (sh_key0[a] < sh_key0[b]) ? -1 : (sh_key0[a] > sh_key0[b]) ? 1 : 0;
      else c = (sh_key1[a] < sh_key1[b]) ? -1 : (sh_key1[a] > sh_key1[b]) ? 1 : 0;
      if (!asc_bits[i]) c = -c;
      if (c != 0) return c;
    end
    return 0;
  endfunction

  // applies one accepted item to the shadow table, queues the pop result
  task automatic apply_item(input kwm_pkg::in_item_t it);
    kwm_pkg::out_item_t res;
    int best;
    logic limited;
    best = -1;
    case (kwm_pkg::kind_t'(it.kind))
      kwm_pkg::KIND_LOAD: begin
        sh_row[it.run_id] = it.row_index;
        sh_key0[it.run_id] = it.key_first;
        sh_key1[it.run_id] = it.key_second;
        sh_nulls[it.run_id] = {it.key_second_null, it.key_first_null};
        sh_present[it.run_id] = 1'b1;
      end
      kwm_pkg::KIND_EXHAUST: sh_present[it.run_id] = 1'b0;
      kwm_pkg::KIND_CLEAR: begin
        for (int r = 0; r < kwm_pkg::NUM_RUNS; r++) sh_present[r] = 1'b0;
        rows_emitted = '0;
      end
      default: begin
        limited = !limit_off && (rows_emitted >= limit_val);
        if (!limited) begin
          for (int r = 0; r < kwm_pkg::NUM_RUNS; r++) begin
            if (!sh_present[r]) continue;
            if (best < 0 || order_runs(r, best) < 0) best = r;
          end
        end
        if (best < 0) begin
          res = '{out_run: '0, out_row: '0, out_done: 1'b1};
        end else begin
          res = '{out_run: best[2:0], out_row: sh_row[best], out_done: 1'b0};
          sh_present[best] = 1'b0;
          if (rows_emitted != 32'hFFFF_FFFF) rows_emitted++;
        end
        owed_pops = {owed_pops, res};
      end
    endcase
  endtask

  // monitor: check results, then track accepted items and register writes
  always @(posedge clk) begin
    kwm_pkg::out_item_t exp_res;
    if (!rst_n) begin
      took_item = 1'b0;
    end else begin
      if (out_valid) begin
        if (owed_pops.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pop result %p", out_item);
        end else begin
          exp_res = owed_pops.pop_front();
          pops_checked++;
          if (exp_res.out_done) done_seen++;
          if (out_item.out_run !== exp_res.out_run || out_item.out_row !== exp_res.out_row ||
              out_item.out_done !== exp_res.out_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pop mismatch: expected run %0d row %0h done %0b, got run %0d row %0h done %0b",
                       exp_res.out_run, exp_res.out_row, exp_res.out_done,
                       out_item.out_run, out_item.out_row, out_item.out_done);
          end
        end
      end
      took_item = start && !busy;
      if (took_item) apply_item(in_item);
      if (psel && penable && pwrite && pready) begin
        case (kwm_pkg::reg_idx_t'(paddr[4:3]))
          // bit 32 is the sign of the limit: negative means no limit
          kwm_pkg::REG_LIMIT: begin
            limit_off = pwdata[32];
            limit_val = pwdata[31:0];
          end
          kwm_pkg::REG_KEYCNT: keys_used = pwdata[1:0];
          kwm_pkg::REG_ASC: asc_bits = pwdata[1:0];
          default: null_lead_bits = pwdata[1:0];
        endcase
      end
    end
  end

  // driver: one item at a time, random gap after each accepted item
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !took_item) begin
        // still waiting for the block
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
        items_sent++;
        if ($urandom_range(0, 99) < 3) calm = !calm;
        gap_left <= calm ? 0 : $urandom_range(0, 6);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic reg_write(input kwm_pkg::reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // waits for the driver to drain and every pop to be answered
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_items.size() > 0 || start || owed_pops.size() > 0) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [63:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 64'sh8000_0000_0000_0000;
      1: return 64'sh7FFF_FFFF_FFFF_FFFF;
      2: return {$urandom(), $urandom()};
      default: return $signed(64'($urandom_range(0, 6))) - 3;
    endcase
  endfunction

  task automatic add_item(input kwm_pkg::kind_t k, input int run, input logic [31:0] row,
                          input logic signed [63:0] k0, input logic n0,
                          input logic signed [63:0] k1, input logic n1);
    kwm_pkg::in_item_t it;
    it.kind = k;
    it.run_id = run[2:0];
    it.row_index = row;
    it.key_first = k0;
    it.key_first_null = n0;
    it.key_second = k1;
    it.key_second_null = n1;
    pending_items = {pending_items, it};
  endtask

  task automatic add_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        add_item(kwm_pkg::KIND_LOAD, $urandom_range(0, 7), $urandom(), rand_key(),
                 $urandom_range(0, 4) == 0, rand_key(), $urandom_range(0, 4) == 0);
      else if (pick < 85)
        add_item(kwm_pkg::KIND_POP, $urandom_range(0, 7), $urandom(), rand_key(),
                 1'($urandom()), rand_key(), 1'($urandom()));
      else if (pick < 96)
        add_item(kwm_pkg::KIND_EXHAUST, $urandom_range(0, 7), $urandom(), rand_key(),
                 1'($urandom()), rand_key(), 1'($urandom()));
      else
        add_item(kwm_pkg::KIND_CLEAR, $urandom_range(0, 7), $urandom(), rand_key(),
                 1'($urandom()), rand_key(), 1'($urandom()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    limit_off = 1'b1;
    limit_val = '1;
    keys_used = 2'd1;
    asc_bits = 2'b11;
    null_lead_bits = 2'b00;
    for (int r = 0; r < kwm_pkg::NUM_RUNS; r++) sh_present[r] = 1'b0;
    rows_emitted = '0;
    took_item = 1'b0;
    mismatches = 0;
    pops_checked = 0;
    done_seen = 0;
    items_sent = 0;
    gap_left = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: pop on empty, extreme keys, ties, nulls, reload, exhaust, clear
    add_item(kwm_pkg::KIND_POP, 0, 0, 0, 0, 0, 0);
    add_item(kwm_pkg::KIND_LOAD, 0, 32'hFFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
    add_item(kwm_pkg::KIND_LOAD, 1, 32'h0, 64'sh8000_0000_0000_0000, 0, -1, 1);
    add_item(kwm_pkg::KIND_LOAD, 2, 32'h1234, 5, 1, 64'sh8000_0000_0000_0000, 0);
    add_item(kwm_pkg::KIND_LOAD, 7, 32'h77, 5, 0, 64'sh7FFF_FFFF_FFFF_FFFF, 1);
    add_item(kwm_pkg::KIND_LOAD, 3, 32'h33, 5, 0, 9, 0);
    add_item(kwm_pkg::KIND_LOAD, 3, 32'h34, 5, 0, 8, 0);
    add_item(kwm_pkg::KIND_EXHAUST, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) add_item(kwm_pkg::KIND_POP, 0, 0, 0, 0, 0, 0);
    add_item(kwm_pkg::KIND_LOAD, 4, 32'h44, 0, 1, 0, 1);
    add_item(kwm_pkg::KIND_LOAD, 5, 32'h55, 0, 1, 0, 1);
    add_item(kwm_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0);
    add_item(kwm_pkg::KIND_POP, 0, 0, 0, 0, 0, 0);
    settle();

    // random phases under different orderings and limits
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          reg_write(kwm_pkg::REG_LIMIT, 64'h1_FFFF_FFFF);
          reg_write(kwm_pkg::REG_KEYCNT, 2);
          reg_write(kwm_pkg::REG_ASC, 0);
          reg_write(kwm_pkg::REG_NULLF, 3);
        end
        2: begin
          reg_write(kwm_pkg::REG_LIMIT, 0);
          reg_write(kwm_pkg::REG_KEYCNT, 3);
          reg_write(kwm_pkg::REG_ASC, 1);
          reg_write(kwm_pkg::REG_NULLF, 2);
        end
        3: begin
          reg_write(kwm_pkg::REG_LIMIT, 25);
          reg_write(kwm_pkg::REG_KEYCNT, 0);
          reg_write(kwm_pkg::REG_ASC, 2);
          reg_write(kwm_pkg::REG_NULLF, 1);
        end
        4: begin
          reg_write(kwm_pkg::REG_LIMIT, 64'h1_0000_0000);
          reg_write(kwm_pkg::REG_KEYCNT, 2);
          reg_write(kwm_pkg::REG_ASC, 3);
          reg_write(kwm_pkg::REG_NULLF, 0);
        end
        default: begin
          reg_write(kwm_pkg::REG_LIMIT, 60);
          reg_write(kwm_pkg::REG_KEYCNT, 1);
          reg_write(kwm_pkg::REG_ASC, 0);
          reg_write(kwm_pkg::REG_NULLF, 1);
        end
      endcase
      add_item(kwm_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0);
      add_random(330);
      settle();
    end

    $display("sent %0d items, checked %0d pops (%0d done answers) over six orderings",
             items_sent, pops_checked, done_seen);
    if (mismatches == 0 && owed_pops.size() == 0) begin
      $display("k_way_sorted_run_merger verification clean");
    end else begin
      $display("%0d mismatches, %0d pops never answered", mismatches, owed_pops.size());
      $display("k_way_sorted_run_merger verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("k_way_sorted_run_merger verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/kwm_pkg.sv
hdl/kwm_cmp.sv
hdl/k_way_sorted_run_merger.sv
test/tb_k_way_sorted_run_merger.sv
